[hw/rtl/tcst_pkg.sv]
// Shared types, constants and the flag transition function of the TCP state tracker.
package tcst_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 1024;
   localparam logic [3:0] WINDOW_SHIFT_RESET = 4'd10;
   localparam logic [3:0] WINDOW_SHIFT_MAX = 4'd14;

   localparam logic [7:0] F_FIN = 8'h01;
   localparam logic [7:0] F_SYN = 8'h02;
   localparam logic [7:0] F_RST = 8'h04;
   localparam logic [7:0] F_ACK = 8'h10;

   localparam logic [3:0] S_EST        = 4'd1;
   localparam logic [3:0] S_SYN_SENT   = 4'd2;
   localparam logic [3:0] S_SYN_RECV   = 4'd3;
   localparam logic [3:0] S_FW1        = 4'd4;
   localparam logic [3:0] S_FW2        = 4'd5;
   localparam logic [3:0] S_TIME_WAIT  = 4'd6;
   localparam logic [3:0] S_CLOSE      = 4'd7;
   localparam logic [3:0] S_CLOSE_WAIT = 4'd8;
   localparam logic [3:0] S_LAST_ACK   = 4'd9;
   localparam logic [3:0] S_CLOSING    = 4'd11;

   localparam logic CMD_INSTALL = 1'b0;
   localparam logic CMD_INSPECT = 1'b1;

   typedef struct packed {
      logic        command;
      logic [7:0]  protocol;
      logic [31:0] sender_ip;
      logic [31:0] target_ip;
      logic [15:0] sender_port;
      logic [15:0] target_port;
      logic [7:0]  seg_flags;
      logic [31:0] seq_num;
      logic [31:0] ack_num;
      logic [15:0] window_size;
   } req_type;

   typedef struct packed {
      logic verdict;
      logic entry_found;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] server_seq;
      logic [31:0] client_seq;
      logic [3:0]  server_state;
      logic [3:0]  client_state;
      logic [29:0] server_window;
      logic [29:0] client_window;
   } entry_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] ns;
      logic [3:0] nr;
      logic       chal;
   } trans_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK
   } fsm_type;

   function automatic trans_type closing_rule(input logic [7:0] raw, input logic [3:0] rcv);
      trans_type t;
      t = '0;
      if ((raw & (F_ACK | F_FIN | F_SYN)) == F_ACK) begin
         t.ok = 1'b1;
         t.ns = S_CLOSE;
         t.nr = ((raw & F_RST) != 8'd0) ? S_CLOSE : rcv;
      end
      return t;
   endfunction

   function automatic trans_type transition(input logic [3:0] snd, input logic [3:0] rcv,
                                            input logic [7:0] raw);
      trans_type t;
      logic [7:0] f;
      t = '0;
      f = raw & (F_ACK | F_FIN | F_SYN | F_RST);
      case (snd)
         S_EST: begin
            if (f == F_ACK) t = '{1'b1, S_EST, S_EST, 1'b0};
            else if (f == (F_FIN | F_ACK)) t = '{1'b1, S_FW1, S_CLOSE_WAIT, 1'b0};
            else if (f == (F_ACK | F_RST)) t = '{1'b1, S_CLOSE, S_CLOSE, 1'b0};
         end
         S_CLOSE: begin
            if (f == F_SYN) t = '{1'b1, S_SYN_SENT, S_SYN_RECV, 1'b0};
         end
         S_SYN_RECV: begin
            if (f == (F_SYN | F_ACK)) t = '{1'b1, snd, S_EST, 1'b0};
            else if (f == F_SYN) t = '{1'b1, S_SYN_RECV, S_SYN_RECV, 1'b0};
            else if (f == (F_FIN | F_ACK)) t = '{1'b1, S_FW1, S_CLOSE_WAIT, 1'b0};
            else if (f == (F_RST | F_ACK)) t = '{1'b1, S_CLOSE, S_CLOSE, 1'b0};
         end
         S_CLOSE_WAIT: begin
            if (f == F_ACK) t = '{1'b1, S_CLOSE_WAIT, S_FW2, 1'b1};
            else if (f == (F_FIN | F_ACK)) begin
               if (rcv == S_FW1) t = '{1'b1, S_CLOSING, S_CLOSING, 1'b0};
               else t = '{1'b1, S_LAST_ACK, S_TIME_WAIT, 1'b0};
            end
            else if (f == (F_ACK | F_RST)) t = '{1'b1, S_CLOSE, S_CLOSE, 1'b0};
         end
         S_FW1, S_FW2: begin
            if (f == F_ACK) t = '{1'b1, snd, rcv, 1'b0};
            else t = closing_rule(raw, rcv);
         end
         S_TIME_WAIT: begin
            if (f == F_ACK) t = '{1'b1, S_CLOSE, S_CLOSE, 1'b0};
            else t = closing_rule(raw, rcv);
         end
         S_CLOSING: t = closing_rule(raw, rcv);
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic serial_lt(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

endpackage

[hw/rtl/tcst_table.sv]
// Flow table: valid bits with a clearing pass, and a synchronous entry memory.
module tcst_table
   import tcst_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   localparam int IW = $clog2(TABLE_ENTRIES)
) (
   input  logic            clock,
   input  logic            reset,
   output logic            clearing,
   input  logic            rd_en,
   input  logic [IW-1:0]   rd_idx,
   output logic            rd_valid,
   output entry_type       rd_entry,
   input  logic            wr_en,
   input  logic [IW-1:0]   wr_idx,
   input  entry_type       wr_entry
);

   entry_type               entry_mem [TABLE_ENTRIES];
   logic [IW:0]             clr_cnt_ff, clr_cnt_in;
   logic                    clearing_ff, clearing_in;

   // valid bits live in a one-bit-wide memory, swept after reset
   logic vmem [TABLE_ENTRIES];

   assign clearing = clearing_ff;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == (IW+1)'(TABLE_ENTRIES - 1)) clearing_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clearing_ff <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) vmem[clr_cnt_ff[IW-1:0]] <= 1'b0;
      else if (wr_en) vmem[wr_idx] <= 1'b1;
      if (rd_en) rd_valid <= vmem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_idx] <= wr_entry;
      if (rd_en) rd_entry <= entry_mem[rd_idx];
   end

endmodule

[hw/rtl/tcp_connection_state_tracker_top.sv]
// Top level of the TCP connection state tracker.
//
// Channels: a request is taken when start is high and busy low. Each request
// yields one response on rsp_data, shown for one cycle with rsp_strobe high;
// the receiver cannot stall, so no output backpressure exists.
// Configuration: csr_we with csr_wdata writes window_shift (reset 10); write
// it only while the block is idle.
// Steps from acceptance to strobe: table read, check, write back. One request at
// a time: busy stays high from acceptance until the response, so no new request
// is taken before the last one is through, set by the state machine holding busy
// through the read and check cycles; the entry is written back at the edge that
// ends the check cycle, before the next read can start.
// Reset: synchronous, active high. After reset a clearing pass sweeps the
// valid bits of all TABLE_ENTRIES entries (1024 by default), one entry a cycle;
// busy stays high during it.
// Install writes a fresh CLOSE/CLOSE entry; inspect runs the flag transition and
// sequence window checks and writes back the updated entry on a non-challenge pass.
module tcp_connection_state_tracker_top
   import tcst_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data,
   input  logic       csr_we,
   input  logic [3:0] csr_wdata
);

   localparam int IW = $clog2(TABLE_ENTRIES);

   fsm_type   state_ff, state_in;
   req_type   req_ff;
   logic [31:0] key_ff;
   logic [3:0] shift_ff;
   logic      clearing, rd_valid, wr_en, rd_en;
   entry_type rd_entry, wr_entry;
   logic      strobe_ff, strobe_in;
   rsp_type   rsp_ff, rsp_in;
   logic [31:0] key_c;

   assign key_c = req_data.sender_ip ^ req_data.target_ip ^ {16'd0, req_data.sender_port}
                ^ {16'd0, req_data.target_port} ^ {24'd0, req_data.protocol};

   tcst_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
      .clock, .reset, .clearing,
      .rd_en, .rd_idx(key_c[IW-1:0]), .rd_valid, .rd_entry,
      .wr_en, .wr_idx(key_ff[IW-1:0]), .wr_entry
   );

   assign busy = (state_ff != ST_IDLE) || clearing;
   assign rd_en = start && !busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (rd_en) state_in = ST_READ;
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         shift_ff  <= WINDOW_SHIFT_RESET;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         if (csr_we) shift_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         req_ff <= req_data;
         key_ff <= key_c;
      end
      rsp_ff <= rsp_in;
   end

   // check stage: decide on the entry read from the table at acceptance
   logic        hit, srv, pass, ok_seq, chal_pass;
   trans_type   tr;
   logic [3:0]  snd, rcv, ns;
   logic [31:0] sseq, rseq, sack;
   logic [29:0] swin, nwin;
   logic [3:0]  sh;
   logic [45:0] wide_win;

   always_comb begin
      hit  = rd_valid && (rd_entry.key == key_ff);
      srv  = req_ff.sender_ip < req_ff.target_ip;
      snd  = srv ? rd_entry.server_state : rd_entry.client_state;
      rcv  = srv ? rd_entry.client_state : rd_entry.server_state;
      sseq = srv ? rd_entry.server_seq : rd_entry.client_seq;
      swin = srv ? rd_entry.server_window : rd_entry.client_window;
      rseq = srv ? rd_entry.client_seq : rd_entry.server_seq;
      tr   = transition(snd, rcv, req_ff.seg_flags);
      sack = sseq + {2'd0, swin};
      ok_seq = ((req_ff.seg_flags & F_SYN) != 8'd0)
            || (!serial_lt(req_ff.seq_num, sseq) && serial_lt(req_ff.seq_num, sack));
      chal_pass = tr.chal && serial_lt(req_ff.ack_num, rseq)
               && serial_lt(req_ff.seq_num, rd_entry.server_seq);
      ns = tr.ns;
      if (ns == S_CLOSING && tr.nr == S_CLOSING && req_ff.ack_num != rseq
          && !serial_lt(req_ff.ack_num, rseq)) ns = S_CLOSE;
      sh = (shift_ff > WINDOW_SHIFT_MAX) ? WINDOW_SHIFT_MAX : shift_ff;
      wide_win = {30'd0, req_ff.window_size} << sh;
      nwin = wide_win[29:0];
      pass = hit && tr.ok && ok_seq;

      wr_entry = rd_entry;
      wr_en = 1'b0;
      rsp_in = '0;
      strobe_in = 1'b0;
      if (state_ff == ST_CHECK) begin
         strobe_in = 1'b1;
         rsp_in.entry_found = hit;
         if (req_ff.command == CMD_INSTALL) begin
            wr_en = 1'b1;
            wr_entry = '{key_ff, 32'd0, 32'd0, S_CLOSE, S_CLOSE, 30'd0, 30'd0};
            rsp_in.verdict = 1'b1;
         end else if (pass) begin
            rsp_in.verdict = 1'b1;
            if (!chal_pass) begin
               wr_en = 1'b1;
               if (srv) begin
                  wr_entry.client_seq    = req_ff.ack_num;
                  wr_entry.client_window = nwin;
                  wr_entry.server_state  = ns;
                  wr_entry.client_state  = tr.nr;
               end else begin
                  wr_entry.server_seq    = req_ff.ack_num;
                  wr_entry.server_window = nwin;
                  wr_entry.client_state  = ns;
                  wr_entry.server_state  = tr.nr;
               end
               if (((req_ff.seg_flags & F_RST) != 8'd0) || (ns == S_CLOSE && tr.nr == S_CLOSE))
               begin
                  wr_entry.client_seq = 32'd0;
                  wr_entry.server_seq = 32'd0;
               end
            end
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[hw/rtl/tcst_checker.sv]
// Port-level checker for the TCP state tracker, bound to the top level.
module tcst_checker
   import tcst_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   a_resp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe) else $error("missing response");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe repeated");

   a_install_forwards: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.command == CMD_INSTALL) |-> ##3 rsp_data.verdict)
      else $error("install not forwarded");

endmodule

bind tcp_connection_state_tracker_top tcst_checker u_tcst_checker (
   .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data
);

[tb/tb_top.sv]
// Self-checking testbench for the TCP connection state tracker top level.
module tb_top
   import tcst_pkg::*;
();

   localparam int SLOTS  = TABLE_ENTRIES_DEFAULT;
   localparam int FLOWS  = 20;
   localparam int PHASES = 5;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [3:0] csr_wdata;

   // Flow table predictor plus the queue of verdicts still owed by the block.
   class flow_scoreboard;
      bit          valid_q[SLOTS];
      logic [31:0] tag[SLOTS];
      logic [31:0] srv_seq[SLOTS];
      logic [31:0] cli_seq[SLOTS];
      logic [3:0]  srv_st[SLOTS];
      logic [3:0]  cli_st[SLOTS];
      logic [29:0] srv_win[SLOTS];
      logic [29:0] cli_win[SLOTS];
      logic [3:0]  shift;
      rsp_type     owed_q[$];
      int          mismatches;
      int          installs;
      int          forwarded;
      int          dropped;
      int          hits;

      function new();
         shift = WINDOW_SHIFT_RESET;
         foreach (valid_q[i]) valid_q[i] = 1'b0;
      endfunction

      function bit seq_before(logic [31:0] a, logic [31:0] b);
         logic [31:0] d;
         d = a - b;
         return d[31];
      endfunction

      // Flag-driven state change; 0 means the segment is refused.
      function bit next_states(input logic [3:0] snd, input logic [3:0] rcv,
                               input logic [7:0] raw, output logic [3:0] ns,
                               output logic [3:0] nr, output bit chal);
         logic [7:0] f;
         bit         closes;
         f      = raw & (F_ACK | F_FIN | F_SYN | F_RST);
         closes = (raw & (F_ACK | F_FIN | F_SYN)) == F_ACK;
         chal   = 1'b0;
         ns     = '0;
         nr     = '0;
         case (snd)
            S_EST: begin
               if (f == F_ACK) begin ns = S_EST; nr = S_EST; end
               else if (f == (F_FIN | F_ACK)) begin ns = S_FW1; nr = S_CLOSE_WAIT; end
               else if (f == (F_ACK | F_RST)) begin ns = S_CLOSE; nr = S_CLOSE; end
               else return 1'b0;
            end
            S_CLOSE: begin
               if (f != F_SYN) return 1'b0;
               ns = S_SYN_SENT;
               nr = S_SYN_RECV;
            end
            S_SYN_RECV: begin
               if (f == (F_SYN | F_ACK)) begin ns = snd; nr = S_EST; end
               else if (f == F_SYN) begin ns = S_SYN_RECV; nr = S_SYN_RECV; end
               else if (f == (F_FIN | F_ACK)) begin ns = S_FW1; nr = S_CLOSE_WAIT; end
               else if (f == (F_ACK | F_RST)) begin ns = S_CLOSE; nr = S_CLOSE; end
               else return 1'b0;
            end
            S_CLOSE_WAIT: begin
               if (f == F_ACK) begin ns = S_CLOSE_WAIT; nr = S_FW2; chal = 1'b1; end
               else if (f == (F_FIN | F_ACK)) begin
                  ns = (rcv == S_FW1) ? S_CLOSING : S_LAST_ACK;
                  nr = (rcv == S_FW1) ? S_CLOSING : S_TIME_WAIT;
               end
               else if (f == (F_ACK | F_RST)) begin ns = S_CLOSE; nr = S_CLOSE; end
               else return 1'b0;
            end
            S_FW1, S_FW2, S_TIME_WAIT, S_CLOSING: begin
               if (f == F_ACK && snd != S_CLOSING) begin
                  ns = (snd == S_TIME_WAIT) ? S_CLOSE : snd;
                  nr = (snd == S_TIME_WAIT) ? S_CLOSE : rcv;
               end
               else if (closes) begin
                  ns = S_CLOSE;
                  nr = ((raw & F_RST) != 8'd0) ? S_CLOSE : rcv;
               end
               else return 1'b0;
            end
            default: return 1'b0;
         endcase
         return 1'b1;
      endfunction

      // Work out the verdict of an accepted request and update the table copy.
      function void note(req_type r);
         logic [31:0] key, sseq, rseq, swin;
         logic [3:0]  snd, rcv, ns, nr, sh;
         logic [29:0] scaled;
         int          idx;
         bit          hit, srv, chal, ok;
         rsp_type     exp;
         key = r.sender_ip ^ r.target_ip ^ {16'd0, r.sender_port} ^ {16'd0, r.target_port}
               ^ {24'd0, r.protocol};
         idx = int'(key % SLOTS);
         hit = valid_q[idx] && tag[idx] == key;
         srv = r.sender_ip < r.target_ip;
         exp.entry_found = hit;
         exp.verdict = 1'b0;
         if (hit) hits++;
         if (r.command == CMD_INSTALL) begin
            valid_q[idx] = 1'b1;
            tag[idx]     = key;
            srv_seq[idx] = '0;
            cli_seq[idx] = '0;
            srv_st[idx]  = S_CLOSE;
            cli_st[idx]  = S_CLOSE;
            srv_win[idx] = '0;
            cli_win[idx] = '0;
            exp.verdict  = 1'b1;
            installs++;
            owed_q.push_back(exp);
            return;
         end
         ok = hit;
         if (ok) begin
            snd = srv ? srv_st[idx] : cli_st[idx];
            rcv = srv ? cli_st[idx] : srv_st[idx];
            ok  = next_states(snd, rcv, r.seg_flags, ns, nr, chal);
         end
         if (ok) begin
            sseq = srv ? srv_seq[idx] : cli_seq[idx];
            swin = {2'b00, srv ? srv_win[idx] : cli_win[idx]};
            rseq = srv ? cli_seq[idx] : srv_seq[idx];
            if ((r.seg_flags & F_SYN) == 8'd0 &&
                (seq_before(r.seq_num, sseq) || !seq_before(r.seq_num, sseq + swin)))
               ok = 1'b0;
         end
         if (ok && chal && seq_before(r.ack_num, rseq) && seq_before(r.seq_num, srv_seq[idx]))
         begin
            // challenge ACK: forward, touch nothing
            exp.verdict = 1'b1;
         end
         else if (ok) begin
            if (ns == S_CLOSING && nr == S_CLOSING && r.ack_num != rseq &&
                !seq_before(r.ack_num, rseq))
               ns = S_CLOSE;
            sh = (shift > WINDOW_SHIFT_MAX) ? WINDOW_SHIFT_MAX : shift;
            scaled = 30'({14'd0, r.window_size} << sh);
            if (srv) begin
               cli_seq[idx] = r.ack_num;
               cli_win[idx] = scaled;
               srv_st[idx]  = ns;
               cli_st[idx]  = nr;
            end
            else begin
               srv_seq[idx] = r.ack_num;
               srv_win[idx] = scaled;
               cli_st[idx]  = ns;
               srv_st[idx]  = nr;
            end
            if ((r.seg_flags & F_RST) != 8'd0 || (ns == S_CLOSE && nr == S_CLOSE)) begin
               srv_seq[idx] = '0;
               cli_seq[idx] = '0;
            end
            exp.verdict = 1'b1;
         end
         if (exp.verdict) forwarded++;
         else dropped++;
         owed_q.push_back(exp);
      endfunction

      function void check(rsp_type got);
         rsp_type exp;
         if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response %b with none outstanding", got);
            return;
         end
         exp = owed_q.pop_front();
         if (got.verdict !== exp.verdict || got.entry_found !== exp.entry_found) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: verdict exp %b got %b, entry_found exp %b got %b",
                        exp.verdict, got.verdict, exp.entry_found, got.entry_found);
         end
      endfunction
   endclass

   flow_scoreboard sb;

   // Flow pool: each flow is an address/port pair seen from both ends.
   logic [31:0] flow_a[FLOWS];
   logic [31:0] flow_b[FLOWS];
   logic [15:0] port_a[FLOWS];
   logic [15:0] port_b[FLOWS];
   logic [7:0]  flow_proto[FLOWS];
   logic [7:0]  flag_menu[8];
   int          burst_left;

   tcp_connection_state_tracker_top u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Sample both channels on the rising edge, before the block's updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check(rsp_data);
         if (start && !busy) sb.note(req_data);
      end
   end

   // Build a segment on flow f; fwd picks the end that sends. With good set the
   // sequence number is placed inside the sender's window, if that is nonzero.
   function automatic req_type segment(int f, bit fwd, logic [7:0] flags, bit good);
      req_type     r;
      logic [31:0] key, sseq, rseq;
      logic [29:0] swin;
      int          idx;
      bit          srv;
      r.command     = CMD_INSPECT;
      r.protocol    = flow_proto[f];
      r.sender_ip   = fwd ? flow_a[f] : flow_b[f];
      r.target_ip   = fwd ? flow_b[f] : flow_a[f];
      r.sender_port = fwd ? port_a[f] : port_b[f];
      r.target_port = fwd ? port_b[f] : port_a[f];
      r.seg_flags   = flags;
      key = r.sender_ip ^ r.target_ip ^ {16'd0, r.sender_port} ^ {16'd0, r.target_port}
            ^ {24'd0, r.protocol};
      idx  = int'(key % SLOTS);
      srv  = r.sender_ip < r.target_ip;
      sseq = srv ? sb.srv_seq[idx] : sb.cli_seq[idx];
      swin = srv ? sb.srv_win[idx] : sb.cli_win[idx];
      rseq = srv ? sb.cli_seq[idx] : sb.srv_seq[idx];
      if (!sb.valid_q[idx]) begin
         sseq = $urandom;
         rseq = $urandom;
         swin = '0;
      end
      if (good && swin != '0) r.seq_num = sseq + $urandom_range(0, swin - 1);
      else if ($urandom_range(0, 1)) r.seq_num = sseq + {2'b00, swin};
      else if ($urandom_range(0, 1)) r.seq_num = sseq - 1;
      else r.seq_num = $urandom;
      case ($urandom_range(0, 5))
         0: r.ack_num = rseq - $urandom_range(1, 100);
         1: r.ack_num = $urandom;
         2: r.ack_num = rseq;
         default: r.ack_num = rseq + $urandom_range(1, 5000);
      endcase
      case ($urandom_range(0, 7))
         0: r.window_size = 16'hFFFF;
         1: r.window_size = 16'h0000;
         default: r.window_size = 16'($urandom_range(1, 65535));
      endcase
      return r;
   endfunction

   function automatic req_type install_of(int f);
      req_type r;
      r = segment(f, $urandom_range(0, 1), 8'h00, 1'b0);
      r.command = CMD_INSTALL;
      return r;
   endfunction

   // Present one request, holding it until taken; gaps come between bursts.
   task automatic issue(req_type r);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
      end
      start    <= 1'b1;
      req_data <= r;
      while (busy) @(negedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   // Hold off until every owed verdict has come back and the pipe is empty.
   task automatic drain();
      start <= 1'b0;
      burst_left = 0;
      while (sb.owed_q.size() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   task automatic write_shift(logic [3:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.shift = v;
   endtask

   initial begin
      req_type r;
      int      f;
      logic [3:0] shift_plan[PHASES];
      sb = new();
      flag_menu = '{F_SYN, F_SYN | F_ACK, F_ACK, F_ACK, F_FIN | F_ACK,
                    F_RST | F_ACK, F_ACK | 8'h08, F_ACK | F_FIN | F_RST};
      for (int i = 0; i < FLOWS; i++) begin
         flow_a[i]     = $urandom;
         flow_b[i]     = $urandom;
         port_a[i]     = 16'($urandom);
         port_b[i]     = 16'($urandom);
         flow_proto[i] = 8'd6;
      end
      // flow 1 lands on flow 0's slot with a different tag; flow 2 has equal addresses
      flow_a[1] = flow_a[0];
      flow_b[1] = flow_b[0] ^ 32'h0000_0400;
      port_a[1] = port_a[0];
      port_b[1] = port_b[0];
      flow_b[2] = flow_a[2];
      flow_proto[3] = 8'hFF;
      shift_plan = '{4'd0, 4'd14, 4'd15, 4'd5, 4'd10};

      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      burst_left = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed opening at the reset shift: misses, extremes, a full handshake.
      r = '0;
      r.command = CMD_INSPECT;
      issue(r);
      r = '1;
      r.command = CMD_INSTALL;
      issue(r);
      r.command = CMD_INSPECT;
      issue(r);
      issue(install_of(0));
      issue(install_of(0));
      issue(segment(0, 1'b1, F_ACK, 1'b1));
      issue(segment(0, 1'b1, F_SYN, 1'b1));
      issue(segment(0, 1'b0, F_SYN | F_ACK, 1'b1));
      issue(segment(0, 1'b1, F_SYN | F_ACK, 1'b1));
      issue(segment(0, 1'b0, F_ACK, 1'b1));
      issue(segment(0, 1'b1, F_ACK, 1'b0));
      issue(segment(0, 1'b1, F_FIN | F_ACK, 1'b1));
      issue(segment(0, 1'b0, F_ACK, 1'b1));
      issue(segment(0, 1'b0, F_FIN | F_ACK, 1'b1));
      issue(segment(0, 1'b1, F_ACK, 1'b1));
      issue(segment(0, 1'b0, F_RST | F_ACK, 1'b1));
      issue(install_of(1));
      issue(segment(0, 1'b1, F_SYN, 1'b1));
      issue(install_of(2));
      issue(segment(2, 1'b1, F_SYN, 1'b1));
      issue(segment(2, 1'b0, 8'hFF, 1'b1));

      // Random phases, each at its own window shift, the extremes included.
      for (int p = 0; p < PHASES; p++) begin
         write_shift(shift_plan[p]);
         for (int n = 0; n < 300; n++) begin
            f = $urandom_range(0, FLOWS - 1);
            case ($urandom_range(0, 19))
               0, 1: issue(install_of(f));
               2, 3: begin
                  r = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom});
                  issue(r);
               end
               default: issue(segment(f, $urandom_range(0, 1),
                                      ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                      : flag_menu[$urandom_range(0, 7)],
                                      $urandom_range(0, 7) != 0));
            endcase
         end
      end

      drain();
      repeat (10) @(negedge clock);
      $display("Covered %0d installs, %0d table hits, %0d forwarded and %0d dropped segments",
               sb.installs, sb.hits, sb.forwarded, sb.dropped);
      $display("across five window shift settings, with %0d mismatches", sb.mismatches);
      if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
         $display("Test completed successfully");
      end
      else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, clearing pass included.
   initial begin
      #3000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
